FILE: hdl/wfcs_pkg.sv
// Types and constants shared by the 802.11 frame classifier and statistics block.
package wfcs_pkg;

    localparam int MAX_FRAME_BYTES = 512;
    localparam int SSID_KEEP_BYTES = 22;
    localparam int SSID_SLOTS      = 22;
    localparam int SSID_TAG_START  = 26;
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int IDX_W           = $clog2(SSID_SLOTS + 1);
    localparam int CNT_W           = 32;
    localparam int LEN_SUM_W       = POS_W + 1;

    localparam logic [1:0] TYPE_MGMT     = 2'd0;
    localparam logic [1:0] TYPE_DATA     = 2'd2;
    localparam logic [3:0] SUB_PROBE_REQ = 4'd4;
    localparam logic [3:0] SUB_PROBE_RSP = 4'd5;
    localparam logic [3:0] SUB_BEACON    = 4'd8;

    localparam logic signed [7:0] RSSI_RESET = -8'sd100;

    typedef struct packed {
        logic [7:0]        byte_value;
        logic              has_byte;
        logic              frame_end;
        logic signed [7:0] frame_rssi;
    } in_item_t;

    typedef struct packed {
        logic [31:0]       packet_count;
        logic [31:0]       beacon_count;
        logic [31:0]       probe_count;
        logic [31:0]       data_count;
        logic [31:0]       other_count;
        logic              data_seen;
        logic signed [7:0] last_rssi;
        logic              ssid_valid;
        logic [4:0]        ssid_length;
        logic [63:0]       ssid_bytes_low;
        logic [63:0]       ssid_bytes_mid;
        logic [47:0]       ssid_bytes_high;
    } out_item_t;

endpackage

FILE: hdl/wifi_frame_classifier_stats_top.sv
// Top level of the 802.11 frame classifier with live frame statistics.
//
// The input channel (s_valid, s_ready, s_item) carries one frame byte per item,
// or an empty end marker when has_byte is low. The item with frame_end high
// closes the frame and carries its RSSI. Items without frame_end produce no
// result. Each frame end produces exactly one statistics snapshot on the result
// channel (m_valid, m_ready, m_item), through the output register or the skid register.
// All per-byte work is done in the cycle the item is accepted, so one item can
// be accepted every cycle while s_ready is high; the throughput is then one item per cycle.
// The result side has an output register and a skid register, so an item is
// still accepted while one snapshot waits for the receiver. When both hold a
// snapshot, s_ready drops until the receiver takes one.
// The synchronous active-low reset clears all counters, the frame position,
// the stored SSID length and presence flag, and sets the last RSSI to -100.
// Bytes beyond the maximum frame size are ignored.
module wifi_frame_classifier_stats_top
    import wfcs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [5:0]       kind_reg, kind_next;
    logic [7:0]       decl_reg, decl_next;
    logic [7:0]       cand_reg [SSID_SLOTS];
    logic [7:0]       cand_next [SSID_SLOTS];
    logic [7:0]       stored_reg [SSID_SLOTS];
    logic [7:0]       stored_next [SSID_SLOTS];
    logic [IDX_W-1:0] stored_len_reg, stored_len_next;
    logic             present_reg, present_next;
    logic [CNT_W-1:0] pkt_cnt_reg, pkt_cnt_next;
    logic [CNT_W-1:0] bcn_cnt_reg, bcn_cnt_next;
    logic [CNT_W-1:0] prb_cnt_reg, prb_cnt_next;
    logic [CNT_W-1:0] dat_cnt_reg, dat_cnt_next;
    logic [CNT_W-1:0] oth_cnt_reg, oth_cnt_next;
    logic             seen_reg, seen_next;
    logic signed [7:0] rssi_reg, rssi_next;

    logic             out_valid_reg, skid_valid_reg;
    out_item_t        out_reg, skid_reg;
    out_item_t        res;

    logic             in_accept;
    logic             produce;
    logic [POS_W-1:0] frame_len;
    logic [POS_W-1:0] tag_off;
    logic [1:0]       f_type;
    logic [3:0]       f_sub;
    logic             commit;
    logic [IDX_W-1:0] keep_len;
    logic [8*SSID_SLOTS-1:0] ssid_flat;

    assign s_ready   = !skid_valid_reg;
    assign in_accept = s_valid && s_ready;
    assign produce   = in_accept && s_item.frame_end;
    assign tag_off   = pos_reg - POS_W'(SSID_TAG_START);

    always_comb begin
        pos_next        = pos_reg;
        kind_next       = kind_reg;
        decl_next       = decl_reg;
        cand_next       = cand_reg;
        stored_next     = stored_reg;
        stored_len_next = stored_len_reg;
        present_next    = present_reg;
        pkt_cnt_next    = pkt_cnt_reg;
        bcn_cnt_next    = bcn_cnt_reg;
        prb_cnt_next    = prb_cnt_reg;
        dat_cnt_next    = dat_cnt_reg;
        oth_cnt_next    = oth_cnt_reg;
        seen_next       = seen_reg;
        rssi_next       = rssi_reg;
        commit          = 1'b0;

        if (in_accept && s_item.has_byte && pos_reg < POS_W'(MAX_FRAME_BYTES)) begin
            if (pos_reg == '0) begin
                kind_next = s_item.byte_value[7:2];
            end else if (pos_reg == POS_W'(SSID_TAG_START - 1)) begin
                decl_next = s_item.byte_value;
            end else if (pos_reg >= POS_W'(SSID_TAG_START) &&
                         tag_off < POS_W'(SSID_KEEP_BYTES)) begin
                cand_next[tag_off[IDX_W-1:0]] = s_item.byte_value;
            end
            pos_next = pos_reg + 1'b1;
        end
        frame_len = pos_next;
        f_type    = kind_next[1:0];
        f_sub     = kind_next[5:2];
        keep_len  = (decl_next > 8'(SSID_KEEP_BYTES)) ?
                    IDX_W'(SSID_KEEP_BYTES) : decl_next[IDX_W-1:0];

        if (produce) begin
            pkt_cnt_next = pkt_cnt_reg + 1'b1;
            rssi_next    = s_item.frame_rssi;
            pos_next     = '0;
            if (frame_len == '0) begin
                oth_cnt_next = oth_cnt_reg + 1'b1;
            end else if (f_type == TYPE_MGMT) begin
                if (f_sub == SUB_BEACON) begin
                    bcn_cnt_next = bcn_cnt_reg + 1'b1;
                end else if (f_sub == SUB_PROBE_REQ) begin
                    prb_cnt_next = prb_cnt_reg + 1'b1;
                    commit = (frame_len >= POS_W'(SSID_TAG_START)) && (decl_next != 8'd0) &&
                             (LEN_SUM_W'(SSID_TAG_START) + LEN_SUM_W'(decl_next)
                              <= LEN_SUM_W'(frame_len));
                end else if (f_sub == SUB_PROBE_RSP) begin
                    prb_cnt_next = prb_cnt_reg + 1'b1;
                end else begin
                    oth_cnt_next = oth_cnt_reg + 1'b1;
                end
            end else if (f_type == TYPE_DATA) begin
                dat_cnt_next = dat_cnt_reg + 1'b1;
                seen_next    = 1'b1;
            end else begin
                oth_cnt_next = oth_cnt_reg + 1'b1;
            end
        end

        if (commit) begin
            stored_next     = cand_next;
            stored_len_next = keep_len;
            present_next    = 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < SSID_SLOTS; i++) begin
            ssid_flat[8*i +: 8] = (IDX_W'(i) < stored_len_next) ? stored_next[i] : 8'd0;
        end
        res.packet_count    = pkt_cnt_next;
        res.beacon_count    = bcn_cnt_next;
        res.probe_count     = prb_cnt_next;
        res.data_count      = dat_cnt_next;
        res.other_count     = oth_cnt_next;
        res.data_seen       = seen_next;
        res.last_rssi       = rssi_next;
        res.ssid_valid      = present_next;
        res.ssid_length     = 5'(stored_len_next);
        res.ssid_bytes_low  = ssid_flat[63:0];
        res.ssid_bytes_mid  = ssid_flat[127:64];
        res.ssid_bytes_high = ssid_flat[175:128];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            kind_reg       <= '0;
            decl_reg       <= '0;
            stored_len_reg <= '0;
            present_reg    <= 1'b0;
            pkt_cnt_reg    <= '0;
            bcn_cnt_reg    <= '0;
            prb_cnt_reg    <= '0;
            dat_cnt_reg    <= '0;
            oth_cnt_reg    <= '0;
            seen_reg       <= 1'b0;
            rssi_reg       <= RSSI_RESET;
        end else begin
            pos_reg        <= pos_next;
            kind_reg       <= kind_next;
            decl_reg       <= decl_next;
            stored_len_reg <= stored_len_next;
            present_reg    <= present_next;
            pkt_cnt_reg    <= pkt_cnt_next;
            bcn_cnt_reg    <= bcn_cnt_next;
            prb_cnt_reg    <= prb_cnt_next;
            dat_cnt_reg    <= dat_cnt_next;
            oth_cnt_reg    <= oth_cnt_next;
            seen_reg       <= seen_next;
            rssi_reg       <= rssi_next;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg   <= cand_next;
        stored_reg <= stored_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= produce;
            end
        end else if (produce) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (produce) begin
            skid_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds an item while the output register is empty.");

    a_packet_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        produce |=> pkt_cnt_reg == $past(pkt_cnt_reg) + 1'b1)
        else $error("Packet counter did not advance by one at frame end.");

    a_ssid_len_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        present_reg == (stored_len_reg != '0))
        else $error("SSID presence flag disagrees with the stored SSID length.");

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_FRAME_BYTES))
        else $error("Frame byte position exceeds the maximum frame size.");

    a_frame_end_clears_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        produce |=> pos_reg == '0)
        else $error("Frame byte position not cleared after frame end.");

endmodule
